// ===== design/avcd_pkg.sv =====
package avcd_pkg;

	// Default width of the running chunk counter.
	localparam int FRAME_COUNT_WIDTH_DEF = 24;

	// Field widths fixed by the word format.
	localparam int BYTE_W       = 8;
	localparam int KIND_W       = 3;
	localparam int FRAME_NUM_W  = 24;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 24;
	localparam int BLOCK_W      = 16;
	localparam int PAD_W        = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AUDIO_KIND    = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_FRAME_LIMIT   = 2'd2,
		REG_START_ALIGN   = 2'd3
	} reg_index_t;

	// Audio codec codes held in the audio kind register.
	localparam logic [2:0] AK_NONE         = 3'd0;
	localparam logic [2:0] AK_FAST_MONO    = 3'd1;
	localparam logic [2:0] AK_FAST_STEREO  = 3'd2;
	localparam logic [2:0] AK_PCM          = 3'd3;
	localparam logic [2:0] AK_ADPCM        = 3'd4;
	localparam logic [2:0] AK_ADPCM_STEREO = 3'd5;
	localparam logic [2:0] AK_VORBIS       = 3'd6;

	// Codec block size per channel.
	localparam logic [7:0] FAST_BLOCK  = 8'd40;
	localparam logic [7:0] PCM_BLOCK   = 8'd2;
	localparam logic [7:0] ADPCM_BLOCK = 8'd132;

	// Result codes.
	typedef enum logic [KIND_W-1:0] {
		KIND_VIDEO       = 3'd0,
		KIND_AUDIO       = 3'd1,
		KIND_EMPTY_VIDEO = 3'd2,
		KIND_END         = 3'd3,
		KIND_SIZE_ERROR  = 3'd4
	} result_kind_t;

	// Deframer phases.
	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_VIDEO  = 3'd1,
		PH_AUDIO  = 3'd2,
		PH_EXT    = 3'd3,
		PH_PAD    = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	// Configuration as seen by the deframer core.
	typedef struct packed {
		logic [2:0]  audio_kind;
		logic [7:0]  channel_count;
		logic [23:0] frame_limit;
		logic        align_load;
		logic [1:0]  start_alignment;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic                   valid;
		result_kind_t           kind;
		logic [BYTE_W-1:0]      payload;
		logic                   last;
		logic [FRAME_NUM_W-1:0] frame;
	} result_t;

	// Codec block size in bytes; zero means the audio packet is never extended.
	function automatic logic [BLOCK_W-1:0] block_size(input logic [2:0] kind,
			input logic [7:0] chans);
		logic [BLOCK_W-1:0] size;
		unique case (kind)
			AK_FAST_MONO, AK_FAST_STEREO: size = BLOCK_W'(chans) * BLOCK_W'(FAST_BLOCK);
			AK_PCM:                       size = BLOCK_W'(chans) * BLOCK_W'(PCM_BLOCK);
			AK_ADPCM, AK_ADPCM_STEREO:    size = BLOCK_W'(chans) * BLOCK_W'(ADPCM_BLOCK);
			default:                      size = '0;
		endcase
		return size;
	endfunction

endpackage

// ===== design/avcd_chunk_fsm.sv =====
module avcd_chunk_fsm #(
	parameter int FRAME_COUNT_WIDTH = avcd_pkg::FRAME_COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  avcd_pkg::cfg_t                cfg,
	input  logic                          step,
	input  logic [avcd_pkg::BYTE_W-1:0]   in_byte,
	output avcd_pkg::result_t             res
);
	import avcd_pkg::*;

	phase_t                       phase_q, phase_d;
	logic [2:0]                   hdr_q, hdr_d;
	logic [31:0]                  chunk_q, chunk_d;
	logic [31:0]                  video_q, video_d;
	logic [31:0]                  audio_q, audio_d;
	logic [31:0]                  bytes_left_q, bytes_left_d;
	logic [BLOCK_W-1:0]           block_q, block_d;
	logic [BLOCK_W-1:0]           blkpos_q, blkpos_d;
	logic [PAD_W-1:0]             pad_q, pad_d;
	logic [PAD_W-1:0]             pad_to_audio_q, pad_to_audio_d;
	logic [PAD_W-1:0]             pad_left_q, pad_left_d;
	logic [1:0]                   pos_q;
	logic [FRAME_COUNT_WIDTH-1:0] frame_q, frame_d;

	logic [31:0]        frame_ext;
	logic               limit_hit;
	logic [31:0]        video_full;
	logic               size_err;
	logic [31:0]        audio_full;
	logic [1:0]         end_mod;
	logic [PAD_W-1:0]   pad_calc;
	logic [BLOCK_W:0]   blkpos_inc;
	logic [BLOCK_W-1:0] blkpos_next;
	logic [BLOCK_W-1:0] need;
	logic [PAD_W-1:0]   ext_calc;

	// Chunk limit check, made at the first header byte of a chunk.
	assign frame_ext = 32'(frame_q);
	assign limit_hit = (cfg.frame_limit != '0) && (frame_ext >= 32'(cfg.frame_limit));

	// Header decode on the eighth byte: sizes, audio length and alignment pad.
	assign video_full = {in_byte, video_q[31:8]};
	assign size_err   = {1'b0, chunk_q} < ({1'b0, video_full} + 33'd8);
	assign audio_full = chunk_q - video_full - 32'd8;
	assign end_mod    = pos_q + 2'd1 + chunk_q[1:0];
	assign pad_calc   = 3'd4 - {1'b0, end_mod};

	// Running audio position within the codec block, and the extension
	// needed to finish the block once the last audio byte is seen.
	assign blkpos_inc  = {1'b0, blkpos_q} + 17'd1;
	assign blkpos_next = (blkpos_inc == {1'b0, block_q}) ? '0 : blkpos_inc[BLOCK_W-1:0];
	assign need        = block_q - blkpos_next;
	always_comb begin
		if (block_q == '0 || blkpos_next == '0) begin
			ext_calc = '0;
		end else if (need <= BLOCK_W'(pad_q)) begin
			ext_calc = need[PAD_W-1:0];
		end else begin
			ext_calc = pad_q;
		end
	end

	// Next state for one word.
	always_comb begin
		phase_d        = phase_q;
		hdr_d          = hdr_q;
		chunk_d        = chunk_q;
		video_d        = video_q;
		audio_d        = audio_q;
		bytes_left_d   = bytes_left_q;
		block_d        = block_q;
		blkpos_d       = blkpos_q;
		pad_d          = pad_q;
		pad_to_audio_d = pad_to_audio_q;
		pad_left_d     = pad_left_q;
		frame_d        = frame_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_q == 3'd0 && limit_hit) begin
					phase_d = PH_DONE;
				end else begin
					hdr_d = hdr_q + 3'd1;
					if (hdr_q < 3'd4) begin
						chunk_d = {in_byte, chunk_q[31:8]};
					end else begin
						video_d = video_full;
					end
					if (hdr_q == 3'd7) begin
						if (size_err) begin
							phase_d = PH_DONE;
						end else begin
							pad_d    = pad_calc;
							block_d  = block_size(cfg.audio_kind, cfg.channel_count);
							blkpos_d = '0;
							audio_d  = audio_full;
							if (video_full != '0) begin
								phase_d      = PH_VIDEO;
								bytes_left_d = video_full;
							end else if (audio_full != '0) begin
								phase_d      = PH_AUDIO;
								bytes_left_d = audio_full;
							end else begin
								phase_d    = PH_PAD;
								pad_left_d = pad_calc;
							end
						end
					end
				end
			end
			PH_VIDEO: begin
				bytes_left_d = bytes_left_q - 32'd1;
				if (bytes_left_q == 32'd1) begin
					if (audio_q != '0) begin
						phase_d      = PH_AUDIO;
						bytes_left_d = audio_q;
					end else begin
						phase_d    = PH_PAD;
						pad_left_d = pad_q;
					end
				end
			end
			PH_AUDIO: begin
				blkpos_d     = blkpos_next;
				bytes_left_d = bytes_left_q - 32'd1;
				if (bytes_left_q == 32'd1) begin
					if (ext_calc == '0) begin
						phase_d    = PH_PAD;
						pad_left_d = pad_q;
					end else begin
						phase_d        = PH_EXT;
						pad_to_audio_d = ext_calc;
						pad_left_d     = pad_q - ext_calc;
					end
				end
			end
			PH_EXT: begin
				pad_to_audio_d = pad_to_audio_q - 3'd1;
				if (pad_to_audio_q == 3'd1) begin
					if (pad_left_q == '0) begin
						phase_d = PH_HEADER;
						frame_d = frame_q + 1'b1;
					end else begin
						phase_d = PH_PAD;
					end
				end
			end
			PH_PAD: begin
				pad_left_d = pad_left_q - 3'd1;
				if (pad_left_q == 3'd1) begin
					phase_d = PH_HEADER;
					frame_d = frame_q + 1'b1;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	// Result word for the current input byte.
	always_comb begin
		res.valid   = 1'b0;
		res.kind    = KIND_VIDEO;
		res.payload = '0;
		res.last    = 1'b0;
		res.frame   = frame_ext[FRAME_NUM_W-1:0];
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_q == 3'd0 && limit_hit) begin
					res.valid = 1'b1;
					res.kind  = KIND_END;
				end else if (hdr_q == 3'd7) begin
					if (size_err) begin
						res.valid = 1'b1;
						res.kind  = KIND_SIZE_ERROR;
					end else if (video_full == '0) begin
						res.valid = 1'b1;
						res.kind  = KIND_EMPTY_VIDEO;
					end
				end
			end
			PH_VIDEO: begin
				res.valid   = 1'b1;
				res.kind    = KIND_VIDEO;
				res.payload = in_byte;
				res.last    = (bytes_left_q == 32'd1);
			end
			PH_AUDIO: begin
				res.valid   = 1'b1;
				res.kind    = KIND_AUDIO;
				res.payload = in_byte;
				res.last    = (bytes_left_q == 32'd1) && (ext_calc == '0);
			end
			PH_EXT: begin
				res.valid   = 1'b1;
				res.kind    = KIND_AUDIO;
				res.payload = in_byte;
				res.last    = (pad_to_audio_q == 3'd1);
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			hdr_q          <= '0;
			bytes_left_q   <= '0;
			blkpos_q       <= '0;
			pad_q          <= '0;
			pad_to_audio_q <= '0;
			pad_left_q     <= '0;
			frame_q        <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			hdr_q          <= hdr_d;
			bytes_left_q   <= bytes_left_d;
			blkpos_q       <= blkpos_d;
			pad_q          <= pad_d;
			pad_to_audio_q <= pad_to_audio_d;
			pad_left_q     <= pad_left_d;
			frame_q        <= frame_d;
		end
	end

	// Stream position modulo four; a write of the alignment register reloads it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cfg.align_load) begin
			pos_q <= cfg.start_alignment;
		end else if (step) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	// Header fields and per-chunk sizes.
	always_ff @(posedge clk) begin
		if (step) begin
			chunk_q <= chunk_d;
			video_q <= video_d;
			audio_q <= audio_d;
			block_q <= block_d;
		end
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("deframer left the done phase");

	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAD |-> pad_left_q != '0 && pad_left_q <= 3'd4)
		else $error("pad phase with no pad bytes left");

	a_ext_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EXT |-> pad_to_audio_q != '0
			&& ({1'b0, pad_to_audio_q} + {1'b0, pad_left_q}) <= 4'(pad_q))
		else $error("audio extension beyond the pad");

	a_bytes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VIDEO || phase_q == PH_AUDIO) |-> bytes_left_q != '0)
		else $error("packet phase with no bytes left");

	a_frame_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_HEADER |=> frame_q == $past(frame_q))
		else $error("chunk counter moved during a header");

endmodule

// ===== design/av_chunk_byte_deframer.sv =====
// Chunk deframer: takes the container's chunk area one byte per word and routes out
// the video bytes of each chunk, then its audio bytes, extended into the alignment pad
// as far as needed to complete a codec block; a header gives a word only for an empty
// video packet, a size error or the chunk limit, and unused pad bytes give none. It
// accepts one byte in every clock cycle while the output is not stalled; each byte
// goes through the input register, the phase logic and the output register. The audio
// block remainder is kept by a running counter, so no divider is involved. After a
// size error or once the chunk limit is reached the block drops every byte until reset.
// Configuration is to be written only while no byte is in flight; the block does not enforce it.
module av_chunk_byte_deframer #(
	parameter int FRAME_COUNT_WIDTH = avcd_pkg::FRAME_COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_wr_en,
	input  logic [avcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [avcd_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input byte channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [avcd_pkg::BYTE_W-1:0]        data_byte,
	// Result channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [avcd_pkg::KIND_W-1:0]        result_kind,
	output logic [avcd_pkg::BYTE_W-1:0]        payload_byte,
	output logic                               packet_last,
	output logic [avcd_pkg::FRAME_NUM_W-1:0]   frame_number
);
	import avcd_pkg::*;

	logic [2:0]                 audio_kind_q;
	logic [7:0]                 channel_count_q;
	logic [23:0]                frame_limit_q;
	logic                       align_load;
	cfg_t                       cfg;
	logic                       in_valid_s1;
	logic [BYTE_W-1:0]          in_byte_s1;
	logic                       out_valid_s2;
	result_kind_t               kind_s2;
	logic [BYTE_W-1:0]          payload_s2;
	logic                       last_s2;
	logic [FRAME_NUM_W-1:0]     frame_s2;
	logic                       out_ready;
	logic                       step;
	result_t                    res;

	// Configuration registers.
	assign align_load = cfg_wr_en && (reg_index_t'(cfg_index) == REG_START_ALIGN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_kind_q      <= AK_NONE;
			channel_count_q   <= 8'd2;
			frame_limit_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_AUDIO_KIND:    audio_kind_q      <= cfg_data[2:0];
				REG_CHANNEL_COUNT: channel_count_q   <= cfg_data[7:0];
				REG_FRAME_LIMIT:   frame_limit_q     <= cfg_data[23:0];
				// The alignment value loads the stream position counter directly.
				REG_START_ALIGN:   ;
			endcase
		end
	end

	always_comb begin
		cfg.audio_kind      = audio_kind_q;
		cfg.channel_count   = channel_count_q;
		cfg.frame_limit     = frame_limit_q;
		cfg.align_load      = align_load;
		cfg.start_alignment = cfg_data[1:0];
	end

	// Flow control: the input stage moves on whenever the output register can take a word.
	assign out_ready = !out_valid_s2 || !out_stall;
	assign step      = in_valid_s1 && out_ready;
	assign in_stall  = in_valid_s1 && !out_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (step) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_byte_s1 <= data_byte;
		end
	end

	avcd_chunk_fsm #(
		.FRAME_COUNT_WIDTH(FRAME_COUNT_WIDTH)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.in_byte (in_byte_s1),
		.res     (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_ready) begin
			out_valid_s2 <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid && out_ready) begin
			kind_s2    <= res.kind;
			payload_s2 <= res.payload;
			last_s2    <= res.last;
			frame_s2   <= res.frame;
		end
	end

	assign out_valid    = out_valid_s2;
	assign result_kind  = kind_s2;
	assign payload_byte = payload_s2;
	assign packet_last  = last_s2;
	assign frame_number = frame_s2;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import avcd_pkg::*;

	// How the result of one fed byte is predicted.
	typedef enum logic [1:0] {
		CHK_MODEL  = 2'd0,
		CHK_TYPED  = 2'd1,
		CHK_SILENT = 2'd2
	} check_mode_t;

	// One result word as seen on the output ports.
	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   payload;
		logic         last;
		logic [23:0]  frame;
	} deframe_word_t;

	// One line of the opening stimulus table.
	typedef struct packed {
		logic [7:0]    data;
		check_mode_t   mode;
		deframe_word_t word;
	} stim_row_t;

	localparam deframe_word_t NO_WORD = '0;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 150;
	localparam int NUM_PHASES  = 13;
	localparam int QUIET_PHASE = 3;
	localparam int DRAIN_WAIT  = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_AUDIO_KIND;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_kind;
	logic [7:0]  payload_byte;
	logic        packet_last;
	logic [23:0] frame_number;

	// Side information travelling with the byte on the input port.
	check_mode_t   cur_mode = CHK_MODEL;
	deframe_word_t cur_word = '0;

	// Predictor copy of the configuration registers.
	logic [2:0]  cfg_kind = AK_NONE;
	logic [7:0]  cfg_chans = 8'd2;
	logic [23:0] cfg_limit = '0;

	// Predictor copy of the deframer state.
	phase_t      st_phase = PH_HEADER;
	logic [2:0]  hdr_seen = '0;
	logic [31:0] chunk_len = '0;
	logic [31:0] video_len = '0;
	logic [31:0] remain = '0;
	logic [1:0]  pos_mod = '0;
	logic [2:0]  pad_drop = '0;
	logic [2:0]  pad_ext = '0;
	logic [23:0] frame_cnt = '0;

	deframe_word_t expected_words [$];
	deframe_word_t pred_word;
	deframe_word_t want;
	bit            pred_hit;

	bit          idle_en = 1'b1;
	logic [1:0]  gen_pos = '0;
	int          err_count = 0;
	int          bytes_fed = 0;
	int          words_checked = 0;
	int          kind_hits [8];
	int          cycle_count = 0;
	string       closing;

	// Opening table: an empty video chunk, then one byte of video and one of audio.
	stim_row_t intro_rows [24] = '{
		'{8'h08, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_TYPED, '{KIND_EMPTY_VIDEO, 8'h00, 1'b0, 24'd0}},
		'{8'hFF, CHK_MODEL, NO_WORD},
		'{8'h00, CHK_MODEL, NO_WORD},
		'{8'hA5, CHK_MODEL, NO_WORD},
		'{8'h5A, CHK_MODEL, NO_WORD},
		'{8'h0A, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h01, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'h00, CHK_SILENT, NO_WORD},
		'{8'hFF, CHK_TYPED, '{KIND_VIDEO, 8'hFF, 1'b1, 24'd1}},
		'{8'h00, CHK_TYPED, '{KIND_AUDIO, 8'h00, 1'b1, 24'd1}},
		'{8'h80, CHK_MODEL, NO_WORD},
		'{8'h7F, CHK_MODEL, NO_WORD}
	};

	// Fixed settings for the first phases; later phases are drawn at random.
	logic [2:0] plan_kind [7] = '{AK_ADPCM, AK_PCM, AK_FAST_MONO, AK_FAST_STEREO,
		AK_ADPCM_STEREO, AK_VORBIS, AK_NONE};
	logic [7:0] plan_chans [7] = '{8'd1, 8'd255, 8'd1, 8'd2, 8'd0, 8'd2, 8'd6};

	av_chunk_byte_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.packet_last  (packet_last),
		.frame_number (frame_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Codec block length in bytes; zero leaves the audio packet as it is.
	function automatic logic [31:0] codec_block(input logic [2:0] kind, input logic [7:0] chans);
		case (kind)
			AK_FAST_MONO, AK_FAST_STEREO: return 32'(chans) * 32'(FAST_BLOCK);
			AK_PCM:                       return 32'(chans) * 32'(PCM_BLOCK);
			AK_ADPCM, AK_ADPCM_STEREO:    return 32'(chans) * 32'(ADPCM_BLOCK);
			default:                      return 32'd0;
		endcase
	endfunction

	// Step through every phase that has nothing left to consume.
	function automatic void advance_phase();
		bit moving;
		moving = 1'b1;
		while (moving) begin
			if (st_phase == PH_VIDEO && remain == 0) begin
				remain = chunk_len - video_len - 32'd8;
				st_phase = PH_AUDIO;
			end else if (st_phase == PH_AUDIO && remain == 0) begin
				st_phase = PH_EXT;
			end else if (st_phase == PH_EXT && pad_ext == 0) begin
				st_phase = PH_PAD;
			end else if (st_phase == PH_PAD && pad_drop == 0) begin
				st_phase = PH_HEADER;
				hdr_seen = '0;
				frame_cnt = frame_cnt + 24'd1;
				moving = 1'b0;
			end else begin
				moving = 1'b0;
			end
		end
	endfunction

	// Split the alignment pad between audio extension and dropped bytes.
	function automatic void open_chunk(input logic [1:0] pos);
		logic [31:0] audio;
		logic [31:0] block;
		logic [31:0] rem;
		logic [31:0] need;
		logic [1:0]  end_mod;
		logic [2:0]  pad;
		logic [2:0]  ext;
		audio = chunk_len - video_len - 32'd8;
		end_mod = pos + 2'd1 + chunk_len[1:0];
		pad = 3'd4 - {1'b0, end_mod};
		block = codec_block(cfg_kind, cfg_chans);
		ext = '0;
		if (block != 0) begin
			rem = audio % block;
			if (rem != 0) begin
				need = block - rem;
				ext = (need <= 32'(pad)) ? need[2:0] : pad;
			end
		end
		pad_ext = ext;
		pad_drop = pad - ext;
		remain = video_len;
		st_phase = PH_VIDEO;
	endfunction

	// Predict the word, if any, that one accepted byte produces.
	function automatic bit deframe_byte(input logic [7:0] b, output deframe_word_t w);
		logic [1:0] pos;
		logic       empty;
		pos = pos_mod;
		pos_mod = pos + 2'd1;
		w = '0;
		w.frame = frame_cnt;
		case (st_phase)
			PH_HEADER: begin
				if (hdr_seen == 0) begin
					if (cfg_limit != 0 && frame_cnt >= cfg_limit) begin
						st_phase = PH_DONE;
						w.kind = KIND_END;
						return 1'b1;
					end
					chunk_len = '0;
					video_len = '0;
				end
				if (hdr_seen < 3'd4)
					chunk_len = chunk_len | (32'(b) << (8 * hdr_seen));
				else
					video_len = video_len | (32'(b) << (8 * hdr_seen[1:0]));
				hdr_seen = hdr_seen + 3'd1;
				if (hdr_seen != 0)
					return 1'b0;
				if ({1'b0, chunk_len} < {1'b0, video_len} + 33'd8) begin
					st_phase = PH_DONE;
					w.kind = KIND_SIZE_ERROR;
					return 1'b1;
				end
				open_chunk(pos);
				empty = (video_len == 0);
				advance_phase();
				if (empty) begin
					w.kind = KIND_EMPTY_VIDEO;
					return 1'b1;
				end
				return 1'b0;
			end
			PH_VIDEO: begin
				w.kind = KIND_VIDEO;
				w.payload = b;
				w.last = (remain == 1);
				remain = remain - 32'd1;
				advance_phase();
				return 1'b1;
			end
			PH_AUDIO: begin
				w.kind = KIND_AUDIO;
				w.payload = b;
				w.last = (remain == 1 && pad_ext == 0);
				remain = remain - 32'd1;
				advance_phase();
				return 1'b1;
			end
			PH_EXT: begin
				w.kind = KIND_AUDIO;
				w.payload = b;
				w.last = (pad_ext == 1);
				pad_ext = pad_ext - 3'd1;
				advance_phase();
				return 1'b1;
			end
			PH_PAD: begin
				pad_drop = pad_drop - 3'd1;
				advance_phase();
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Check each delivered word, then predict from each accepted byte.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: kind %0d, byte %02h",
					result_kind, payload_byte);
				err_count++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				kind_hits[want.kind]++;
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					err_count++;
				end
				if (payload_byte !== want.payload) begin
					$error("payload_byte: expected %02h, got %02h", want.payload, payload_byte);
					err_count++;
				end
				if (packet_last !== want.last) begin
					$error("packet_last: expected %0d, got %0d", want.last, packet_last);
					err_count++;
				end
				if (frame_number !== want.frame) begin
					$error("frame_number: expected %0d, got %0d", want.frame, frame_number);
					err_count++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			pred_hit = deframe_byte(data_byte, pred_word);
			bytes_fed++;
			case (cur_mode)
				CHK_MODEL:  if (pred_hit) expected_words.push_back(pred_word);
				CHK_TYPED:  expected_words.push_back(cur_word);
				default:    ;
			endcase
		end
	end

	// The receiver stalls at random while idling is enabled.
	always @(negedge clk)
		out_stall <= idle_en && ($urandom_range(0, 99) < 17);

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one byte, with a random gap ahead of it, and hold it until accepted.
	task automatic send_byte(input logic [7:0] b, input check_mode_t mode,
			input deframe_word_t w);
		if (idle_en && $urandom_range(0, 99) < 17) begin
			@(negedge clk);
			in_valid <= 1'b0;
			while ($urandom_range(0, 99) < 40)
				@(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		cur_mode <= mode;
		cur_word <= w;
		gen_pos = gen_pos + 2'd1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Chunk header: little-endian chunk size, then little-endian video size.
	task automatic send_header(input logic [31:0] clen, input logic [31:0] vlen);
		for (int i = 0; i < 4; i++)
			send_byte(clen[8*i +: 8], CHK_MODEL, NO_WORD);
		for (int i = 0; i < 4; i++)
			send_byte(vlen[8*i +: 8], CHK_MODEL, NO_WORD);
	endtask

	// A well-formed chunk with random sizes and content, followed by its pad.
	task automatic send_chunk();
		logic [31:0] vlen;
		logic [31:0] alen;
		logic [31:0] blk;
		logic [31:0] clen;
		logic [1:0]  p0;
		logic [1:0]  end_mod;
		logic [2:0]  pad;
		int unsigned mult;
		vlen = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
		blk = codec_block(cfg_kind, cfg_chans);
		// Audio lengths just short of a block multiple exercise the extension.
		if (blk != 0 && blk <= 200 && $urandom_range(0, 1) == 1) begin
			mult = $urandom_range(1, 200 / blk);
			alen = blk * mult - 32'($urandom_range(0, (blk < 5) ? blk : 5));
		end else if ($urandom_range(0, 4) == 0) begin
			alen = 32'd0;
		end else begin
			alen = 32'($urandom_range(1, 40));
		end
		clen = 32'd8 + vlen + alen;
		p0 = gen_pos;
		send_header(clen, vlen);
		repeat (vlen + alen)
			send_byte(8'($urandom), CHK_MODEL, NO_WORD);
		end_mod = p0 + clen[1:0];
		pad = 3'd4 - {1'b0, end_mod};
		repeat (pad)
			send_byte(8'($urandom), CHK_MODEL, NO_WORD);
	endtask

	// Write one register while the deframer is idle and mirror it in the predictor.
	task automatic cfg_write(input reg_index_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_AUDIO_KIND:    cfg_kind = val[2:0];
			REG_CHANNEL_COUNT: cfg_chans = val[7:0];
			REG_FRAME_LIMIT:   cfg_limit = val;
			default: begin
				pos_mod = val[1:0];
				gen_pos = val[1:0];
			end
		endcase
	endtask

	// Hold the sender until every expected word is out and the pipeline is empty.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		logic [7:0]  chans;
		logic [23:0] limit;
		logic [1:0]  align;
		logic [2:0]  kind;
		logic [31:0] vlen;
		int          target;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Opening table under the reset settings.
		foreach (intro_rows[i])
			send_byte(intro_rows[i].data, intro_rows[i].mode, intro_rows[i].word);

		// Random chunks under a series of settings.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			if (ph < 7) begin
				kind = plan_kind[ph];
				chans = plan_chans[ph];
			end else begin
				kind = 3'($urandom_range(0, 6));
				case ($urandom_range(0, 4))
					0:       chans = 8'd0;
					1:       chans = 8'd1;
					2:       chans = 8'd2;
					3:       chans = 8'd255;
					default: chans = 8'($urandom);
				endcase
			end
			// Nonzero limits stay far above the number of chunks in the run.
			if (ph == 1)
				limit = 24'hFF_FFFF;
			else if ($urandom_range(0, 1) == 0)
				limit = '0;
			else
				limit = 24'($urandom_range(24'h01_0000, 24'hFF_FFFF));
			align = (ph < 4) ? 2'(3 - ph) : 2'($urandom_range(0, 3));
			cfg_write(REG_AUDIO_KIND, 24'(kind));
			cfg_write(REG_CHANNEL_COUNT, 24'(chans));
			cfg_write(REG_FRAME_LIMIT, limit);
			cfg_write(REG_START_ALIGN, 24'(align));
			idle_en = (ph != QUIET_PHASE);
			target = bytes_fed + ((ph == QUIET_PHASE) ? 2 * PHASE_BYTES : PHASE_BYTES);
			while (bytes_fed < target)
				send_chunk();
		end
		idle_en = 1'b1;

		// Close the stream by either the chunk limit or a size error.
		wait_drained();
		if ($urandom_range(0, 1) == 1) begin
			closing = "the chunk limit";
			cfg_write(REG_FRAME_LIMIT, frame_cnt);
			send_byte(8'($urandom), CHK_MODEL, NO_WORD);
		end else begin
			closing = "a size error";
			case ($urandom_range(0, 2))
				0:       send_header(32'hFFFF_FFFF, 32'hFFFF_FFF8);
				1:       send_header(32'd0, 32'd0);
				default: begin
					vlen = 32'($urandom_range(0, 20));
					send_header(vlen + 32'($urandom_range(0, 7)), vlen);
				end
			endcase
		end
		// Everything after the stop must be swallowed.
		repeat (8)
			send_byte(8'($urandom), CHK_MODEL, NO_WORD);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Fed %0d bytes over %0d chunks and %0d settings, stopped by %s.",
			bytes_fed, frame_cnt, NUM_PHASES + 1, closing);
		$display("Checked %0d words: %0d video, %0d audio, %0d empty video, %0d end, %0d size error.",
			words_checked, kind_hits[KIND_VIDEO], kind_hits[KIND_AUDIO],
			kind_hits[KIND_EMPTY_VIDEO], kind_hits[KIND_END], kind_hits[KIND_SIZE_ERROR]);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
